@@ rtl/mono_framebuffer_raster_engine_assert.svh @@
// Assertion macros for the raster engine.
`ifndef MONO_FRAMEBUFFER_RASTER_ENGINE_ASSERT_SVH
`define MONO_FRAMEBUFFER_RASTER_ENGINE_ASSERT_SVH
`ifndef SYNTH
`define MFR_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define MFR_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define MFR_ASSERT_IMP(label, clk, rst_n, a, c)
`define MFR_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

@@ rtl/mfre_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfre_pkg
// Shared constants and types of the raster engine.
// ----------------------------------------------------------------------------
package mfre_pkg;
	localparam int DEF_WIDTH  = 128;
	localparam int DEF_HEIGHT = 64;
	localparam int COORD_W    = 11;

	localparam logic [2:0] KIND_PIXEL  = 3'd0;
	localparam logic [2:0] KIND_LINE   = 3'd1;
	localparam logic [2:0] KIND_CIRCLE = 3'd2;
	localparam logic [2:0] KIND_CLEAR  = 3'd3;
	localparam logic [2:0] KIND_READ   = 3'd4;

	// One pixel request from the sequencer to the store.
	typedef struct packed {
		logic                      valid;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic                      on;
	} plot_req_t;
endpackage

@@ rtl/mfre_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfre_store
// Frame store with pixel read-modify-write, fill sweep and byte read.
// Every plotted pixel is a read followed by a write back.
// ----------------------------------------------------------------------------
module mfre_store
	import mfre_pkg::*;
#(
	parameter int SCREEN_WIDTH  = DEF_WIDTH,
	parameter int SCREEN_HEIGHT = DEF_HEIGHT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  plot_req_t  req,
	output logic       req_busy,
	input  logic       fill_start,
	input  logic       fill_on,
	output logic       fill_busy,
	input  logic       rd_start,
	input  logic [9:0] rd_addr,
	output logic       rd_done,
	output logic [7:0] rd_data
);
	localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;
	localparam int BYTES = SCREEN_WIDTH * PAGES;
	localparam int AW    = $clog2(BYTES);

	logic [7:0]    mem [BYTES];
	logic [AW:0]   fill_cnt_q;
	logic          fill_q;
	logic          fill_on_q;
	logic          rmw_q;
	logic          rd_q;
	logic          rd_in_q;
	logic [AW-1:0] rmw_addr_q;
	logic [7:0]    rmw_mask_q;
	logic          rmw_on_q;
	logic [7:0]    mem_rd_q;
	logic [AW-1:0] rd_idx;
	logic          px_in;
	logic [AW-1:0] px_addr;

	// Clip test and byte address of the requested pixel.
	always_comb begin
		px_in = req.valid && (req.x >= 0) && (req.y >= 0)
			&& (req.x < SCREEN_WIDTH) && (req.y < SCREEN_HEIGHT);
		px_addr = AW'(({{(AW+8){1'b0}}, req.y[COORD_W-1:3]}) * SCREEN_WIDTH
			+ {{(AW+8){1'b0}}, req.x});
		rd_idx = px_in ? px_addr : AW'(rd_addr);
	end

	assign req_busy  = rmw_q;
	assign fill_busy = fill_q;

	// Single read port, single write port.
	always_ff @(posedge clk) begin
		mem_rd_q <= mem[rd_idx];
		if (fill_q)
			mem[fill_cnt_q[AW-1:0]] <= {8{fill_on_q}};
		else if (rmw_q)
			mem[rmw_addr_q] <= rmw_on_q ? (mem_rd_q | rmw_mask_q)
				: (mem_rd_q & ~rmw_mask_q);
	end

	always_ff @(posedge clk) begin
		if (px_in) begin
			rmw_addr_q <= px_addr;
			rmw_mask_q <= 8'(1) << req.y[2:0];
			rmw_on_q   <= req.on;
		end
	end

	// Fill sweep (also the clearing pass after reset) and request control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= 1'b1;
			fill_on_q  <= 1'b0;
			fill_cnt_q <= '0;
			rmw_q      <= 1'b0;
			rd_q       <= 1'b0;
			rd_in_q    <= 1'b0;
		end else begin
			rmw_q <= px_in;
			rd_q  <= rd_start;
			if (rd_start)
				rd_in_q <= ({6'd0, rd_addr} < 16'(BYTES));
			if (fill_start) begin
				fill_q     <= 1'b1;
				fill_on_q  <= fill_on;
				fill_cnt_q <= '0;
			end else if (fill_q) begin
				if (fill_cnt_q == (AW+1)'(BYTES - 1))
					fill_q <= 1'b0;
				fill_cnt_q <= fill_cnt_q + 1'b1;
			end
		end
	end

	assign rd_done = rd_q;
	assign rd_data = rd_in_q ? mem_rd_q : 8'd0;
endmodule

@@ rtl/mfre_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfre_seq
// Command sequencer with one shared adder stepping line and circle state.
// ----------------------------------------------------------------------------
module mfre_seq
	import mfre_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [2:0] kind,
	input  logic [7:0] x_a,
	input  logic [7:0] y_a,
	input  logic [7:0] x_b,
	input  logic [7:0] y_b,
	input  logic [7:0] radius,
	input  logic       color,
	input  logic       store_busy,
	output plot_req_t  req,
	output logic       done
);
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LPLOT = 3'd1;
	localparam logic [2:0] ST_LSTEP = 3'd2;
	localparam logic [2:0] ST_CPLOT = 3'd3;
	localparam logic [2:0] ST_CSTEP = 3'd4;
	localparam logic [2:0] ST_WAIT  = 3'd5;
	localparam int EW = 12;

	logic [2:0]          st_q;
	logic signed [EW-1:0] xa_q, ya_q, xb_q, yb_q, dx_q, dy_q, err_q;
	logic                sx_q, sy_q, on_q;
	logic signed [EW-1:0] px_q, py_q, d_q, cx_q, cy_q;
	logic [2:0]          oct_q;
	logic                xmove_q;
	logic                kind_pix_q, lyes_q;
	logic signed [EW-1:0] e2;
	logic signed [EW-1:0] add_a, add_b, add_y;
	logic signed [EW-1:0] ox, oy;

	// Shared adder.
	assign add_y = add_a + add_b;

	always_comb begin
		e2 = err_q <<< 1;
		add_a = err_q;
		add_b = '0;
		if (st_q == ST_LSTEP) begin
			add_b = (e2 > -dy_q) ? -dy_q : dx_q;
		end else if (st_q == ST_CSTEP) begin
			add_a = d_q;
			add_b = (d_q < 0) ? (px_q <<< 2) + EW'(6)
				: ((px_q - py_q) <<< 2) + EW'(10);
		end
	end

	// Octant point selection for the circle.
	always_comb begin
		case (oct_q)
		3'd0: begin ox = cx_q + px_q; oy = cy_q + py_q; end
		3'd1: begin ox = cx_q + py_q; oy = cy_q + px_q; end
		3'd2: begin ox = cx_q - px_q; oy = cy_q + py_q; end
		3'd3: begin ox = cx_q - py_q; oy = cy_q + px_q; end
		3'd4: begin ox = cx_q + px_q; oy = cy_q - py_q; end
		3'd5: begin ox = cx_q + py_q; oy = cy_q - px_q; end
		3'd6: begin ox = cx_q - px_q; oy = cy_q - py_q; end
		default: begin ox = cx_q - py_q; oy = cy_q - px_q; end
		endcase
	end

	always_comb begin
		req.on = on_q;
		req.valid = 1'b0;
		req.x = COORD_W'(xa_q);
		req.y = COORD_W'(ya_q);
		if (st_q == ST_LPLOT && !store_busy)
			req.valid = 1'b1;
		else if (st_q == ST_CPLOT && !store_busy) begin
			req.valid = 1'b1;
			req.x = COORD_W'(ox);
			req.y = COORD_W'(oy);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (st_q)
			ST_IDLE: begin
				if (start) begin
					on_q <= color;
					xa_q <= EW'(x_a); ya_q <= EW'(y_a);
					xb_q <= EW'(x_b); yb_q <= EW'(y_b);
					dx_q <= (x_b > x_a) ? EW'(x_b - x_a) : EW'(x_a - x_b);
					dy_q <= (y_b > y_a) ? EW'(y_b - y_a) : EW'(y_a - y_b);
					err_q <= ((x_b > x_a) ? EW'(x_b - x_a) : EW'(x_a - x_b))
						- ((y_b > y_a) ? EW'(y_b - y_a) : EW'(y_a - y_b));
					sx_q <= (x_a < x_b);
					sy_q <= (y_a < y_b);
					cx_q <= EW'(x_a); cy_q <= EW'(y_a);
					px_q <= '0; py_q <= EW'(radius);
					d_q  <= EW'(3) - (EW'(radius) <<< 1);
					oct_q <= '0;
					xmove_q <= 1'b0;
					if (kind == KIND_LINE || kind == KIND_PIXEL)
						st_q <= ST_LPLOT;
					else if (kind == KIND_CIRCLE)
						st_q <= ST_CPLOT;
					else
						st_q <= ST_WAIT;
				end
			end
			ST_LPLOT: begin
				if (!store_busy) begin
					if ((xa_q == xb_q && ya_q == yb_q) || kind_pix_q)
						st_q <= ST_WAIT;
					else
						st_q <= ST_LSTEP;
				end
			end
			ST_LSTEP: begin
				// Two adder passes: x update, then y update on the old e2.
				if (!xmove_q) begin
					xmove_q <= 1'b1;
					lyes_q <= (e2 < dx_q);
					if (e2 > -dy_q) begin
						err_q <= add_y;
						xa_q <= sx_q ? EW'(xa_q + 1) : EW'(xa_q - 1);
					end
				end else begin
					xmove_q <= 1'b0;
					if (lyes_q) begin
						err_q <= err_q + dx_q;
						ya_q <= sy_q ? EW'(ya_q + 1) : EW'(ya_q - 1);
					end
					st_q <= ST_LPLOT;
				end
			end
			ST_CPLOT: begin
				if (!store_busy) begin
					oct_q <= oct_q + 1'b1;
					if (oct_q == 3'd7)
						st_q <= ST_CSTEP;
				end
			end
			ST_CSTEP: begin
				d_q <= add_y;
				if (d_q >= 0)
					py_q <= EW'(py_q - 1);
				px_q <= EW'(px_q + 1);
				st_q <= (px_q + 1 <= ((d_q >= 0) ? py_q - 1 : py_q))
					? ST_CPLOT : ST_WAIT;
			end
			ST_WAIT: begin
				if (!store_busy) begin
					done <= 1'b1;
					st_q <= ST_IDLE;
				end
			end
			default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && start)
			kind_pix_q <= (kind == KIND_PIXEL);
	end
endmodule

@@ rtl/mono_framebuffer_raster_engine.sv @@
`timescale 1ns / 1ps
// One command at a time: pixel, line, circle, clear and read each run to completion
// before the next command is taken.
// The shared adder and the store's read-modify-write set the pace.
// Reset runs a clearing pass over all SCREEN_WIDTH*pages bytes (1024 by default)
// during which no command is taken.
// ----------------------------------------------------------------------------
// mono_framebuffer_raster_engine
// Page-organized monochrome frame store with pixel, line and circle drawing, clear and byte read.
// ----------------------------------------------------------------------------
`include "mono_framebuffer_raster_engine_assert.svh"
module mono_framebuffer_raster_engine
	import mfre_pkg::*;
#(
	parameter int SCREEN_WIDTH  = DEF_WIDTH,
	parameter int SCREEN_HEIGHT = DEF_HEIGHT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] kind,
	input  logic [7:0] x_a,
	input  logic [7:0] y_a,
	input  logic [7:0] x_b,
	input  logic [7:0] y_b,
	input  logic [7:0] radius,
	input  logic       color,
	input  logic [9:0] byte_addr,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_data
);
	logic       busy_q;
	logic       accept;
	plot_req_t  req;
	logic       req_busy, fill_busy, rd_done, seq_done;
	logic [7:0] rd_data;
	logic       seq_start, fill_start, rd_start;
	logic       is_read_q;

	assign in_stall = busy_q || fill_busy || out_valid;
	assign accept   = in_valid && !in_stall;
	assign seq_start  = accept && kind != KIND_READ;
	assign fill_start = accept && kind == KIND_CLEAR;
	assign rd_start   = accept && kind == KIND_READ;

	mfre_seq u_seq (
		.clk, .arst_n, .start(seq_start), .kind, .x_a, .y_a, .x_b, .y_b,
		.radius, .color, .store_busy(req_busy || fill_busy), .req,
		.done(seq_done)
	);

	mfre_store #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_store (
		.clk, .arst_n, .req, .req_busy, .fill_start, .fill_on(color), .fill_busy,
		.rd_start, .rd_addr(byte_addr), .rd_done, .rd_data
	);

	// Command tracking and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			out_valid <= 1'b0;
			is_read_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q    <= 1'b1;
				is_read_q <= (kind == KIND_READ);
			end else if (seq_done || rd_done) begin
				busy_q    <= 1'b0;
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall)
				out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_done)
			read_data <= rd_data;
		else if (seq_done)
			read_data <= 8'd0;
	end

	`MFR_ASSERT_NXT(a_no_accept_busy, clk, arst_n, accept, in_stall)
	`MFR_ASSERT_IMP(a_done_only_busy, clk, arst_n, seq_done || rd_done, busy_q)
	`MFR_ASSERT_IMP(a_read_zero_else, clk, arst_n, out_valid && !is_read_q, read_data == 8'd0)
endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raster engine testbench
// Drives pixel, line, circle, clear, read and unused-kind commands with random idle gaps
// on both channels, keeps a local copy of the frame store, and compares every
// returned byte with the value that copy predicts.
// ----------------------------------------------------------------------------
module testbench;
	import mfre_pkg::*;

	localparam int WIDTH       = DEF_WIDTH;
	localparam int HEIGHT      = DEF_HEIGHT;
	localparam int STORE_BYTES = WIDTH * ((HEIGHT + 7) / 8);

	// Scoreboard: shadow frame store and queue of expected read bytes.
	class raster_scoreboard;
		logic [7:0] shadow_store [STORE_BYTES];
		logic [7:0] expected_bytes [$];
		int         mismatches;
		int         checked;

		function void plot(int x, int y, bit on);
			int idx;
			if (x < 0 || y < 0 || x >= WIDTH || y >= HEIGHT)
				return;
			idx = (y / 8) * WIDTH + x;
			if (on)
				shadow_store[idx] = shadow_store[idx] | (8'd1 << (y % 8));
			else
				shadow_store[idx] = shadow_store[idx] & ~(8'd1 << (y % 8));
		endfunction

		function void trace_line(int xa, int ya, int xb, int yb, bit on);
			int dx, dy, sx, sy, err, e2;
			dx = (xb > xa) ? xb - xa : xa - xb;
			dy = (yb > ya) ? yb - ya : ya - yb;
			sx = (xa < xb) ? 1 : -1;
			sy = (ya < yb) ? 1 : -1;
			err = dx - dy;
			forever begin
				plot(xa, ya, on);
				if (xa == xb && ya == yb)
					break;
				e2 = 2 * err;
				if (e2 > -dy) begin
					err -= dy;
					xa += sx;
				end
				if (e2 < dx) begin
					err += dx;
					ya += sy;
				end
			end
		endfunction

		function void trace_circle(int cx, int cy, int r, bit on);
			int px, py, d;
			px = 0;
			py = r;
			d = 3 - 2 * r;
			while (px <= py) begin
				plot(cx + px, cy + py, on);
				plot(cx + py, cy + px, on);
				plot(cx - px, cy + py, on);
				plot(cx - py, cy + px, on);
				plot(cx + px, cy - py, on);
				plot(cx + py, cy - px, on);
				plot(cx - px, cy - py, on);
				plot(cx - py, cy - px, on);
				if (d < 0) begin
					d = d + 4 * px + 6;
				end else begin
					d = d + 4 * (px - py) + 10;
					py--;
				end
				px++;
			end
		endfunction

		function void wipe(logic [7:0] fill);
			foreach (shadow_store[i])
				shadow_store[i] = fill;
		endfunction

		// Applies one accepted command and queues the byte it returns.
		function void note_command(logic [2:0] k, logic [7:0] xa, logic [7:0] ya,
				logic [7:0] xb, logic [7:0] yb, logic [7:0] r, logic c,
				logic [9:0] addr);
			logic [7:0] data;
			data = 8'h00;
			case (k)
				KIND_PIXEL:  plot(xa, ya, c);
				KIND_LINE:   trace_line(xa, ya, xb, yb, c);
				KIND_CIRCLE: trace_circle(xa, ya, r, c);
				KIND_CLEAR:  wipe(c ? 8'hFF : 8'h00);
				KIND_READ:   if (addr < STORE_BYTES) data = shadow_store[addr];
				default:     ;
			endcase
			expected_bytes.push_back(data);
		endfunction

		task check_byte(logic [7:0] got);
			logic [7:0] want;
			checked++;
			if (expected_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected result read_data=%h", got));
				return;
			end
			want = expected_bytes.pop_front();
			if (got !== want)
				report_mismatch($sformatf("read_data got %h want %h", got, want));
		endtask

		task report_mismatch(string msg);
			mismatches++;
			$display("MISMATCH at %0t: %s", $realtime, msg);
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [2:0] kind;
	logic [7:0] x_a, y_a, x_b, y_b, radius;
	logic       color;
	logic [9:0] byte_addr;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] read_data;

	raster_scoreboard board;
	bit quiet_tail;
	int issued;

	mono_framebuffer_raster_engine u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .x_a(x_a), .y_a(y_a), .x_b(x_b), .y_b(y_b),
		.radius(radius), .color(color), .byte_addr(byte_addr),
		.out_valid(out_valid), .out_stall(out_stall), .read_data(read_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sends one command and holds it until the transfer completes.
	task automatic send_command(logic [2:0] k, logic [7:0] xa, logic [7:0] ya,
			logic [7:0] xb, logic [7:0] yb, logic [7:0] r, logic c,
			logic [9:0] addr);
		int gap;
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 9);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k; x_a <= xa; y_a <= ya; x_b <= xb; y_b <= yb;
		radius <= r; color <= c; byte_addr <= addr;
		forever begin
			@(posedge clk);
			if (!in_stall) begin
				board.note_command(k, xa, ya, xb, yb, r, c, addr);
				break;
			end
		end
		@(negedge clk);
		issued++;
	endtask

	task automatic send_random();
		logic [2:0] k;
		logic [7:0] xa, ya, xb, yb, r;
		int sel;
		sel = $urandom_range(0, 99);
		// Mostly on-screen shapes with small sizes; some anywhere in range.
		xa = (sel < 75) ? 8'($urandom_range(0, WIDTH - 1)) : 8'($urandom_range(0, 255));
		ya = (sel < 75) ? 8'($urandom_range(0, HEIGHT - 1)) : 8'($urandom_range(0, 255));
		xb = (sel < 75) ? 8'($urandom_range(0, WIDTH - 1)) : 8'($urandom_range(0, 255));
		yb = (sel < 75) ? 8'($urandom_range(0, HEIGHT - 1)) : 8'($urandom_range(0, 255));
		r = (sel < 90) ? 8'($urandom_range(0, 40)) : 8'($urandom_range(0, 255));
		sel = $urandom_range(0, 99);
		if (sel < 22)      k = KIND_PIXEL;
		else if (sel < 40) k = KIND_LINE;
		else if (sel < 52) k = KIND_CIRCLE;
		else if (sel < 54) k = KIND_CLEAR;
		else if (sel < 97) k = KIND_READ;
		else               k = 3'($urandom_range(5, 7));
		send_command(k, xa, ya, xb, yb, r, $urandom_range(0, 99) < 70,
			(sel % 8 == 0) ? 10'($urandom_range(0, 1023))
				: 10'($urandom_range(0, STORE_BYTES - 1)));
	endtask

	// Result side: random stall bursts, check on every transfer.
	initial begin
		int burst;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 9);
				out_stall <= 1'b1;
				repeat (burst) @(negedge clk);
			end
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			board.check_byte(read_data);

	// Safety limit far above the slowest correct run.
	initial begin
		#200ms;
		$display("Verification failed");
		$finish;
	end

	initial begin
		int wait_cycles;
		board = new();
		board.wipe(8'h00);
		quiet_tail = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_READ; x_a = 0; y_a = 0; x_b = 0; y_b = 0;
		radius = 0; color = 0; byte_addr = 0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: extremes, each kind, clipping, degenerate shapes.
		send_command(KIND_READ, 0, 0, 0, 0, 0, 0, 10'd0);
		send_command(KIND_PIXEL, 0, 0, 0, 0, 0, 1, 0);
		send_command(KIND_PIXEL, 8'(WIDTH - 1), 8'(HEIGHT - 1), 0, 0, 0, 1, 0);
		send_command(KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 10'h3FF);
		send_command(KIND_READ, 0, 0, 0, 0, 0, 0, 10'd0);
		send_command(KIND_READ, 0, 0, 0, 0, 0, 0, 10'(STORE_BYTES - 1));
		send_command(KIND_READ, 0, 0, 0, 0, 0, 0, 10'h3FF);
		send_command(KIND_LINE, 5, 9, 5, 9, 0, 1, 0);
		send_command(KIND_LINE, 0, 0, 255, 255, 0, 1, 0);
		send_command(KIND_LINE, 120, 60, 3, 1, 0, 0, 0);
		send_command(KIND_CIRCLE, 64, 32, 0, 0, 0, 1, 0);
		send_command(KIND_CIRCLE, 2, 2, 0, 0, 20, 1, 0);
		send_command(KIND_CIRCLE, 64, 32, 0, 0, 255, 1, 0);
		send_command(KIND_READ, 0, 0, 0, 0, 0, 0, 10'(4 * WIDTH + 64));
		send_command(3'd5, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 1, 10'h2AA);
		send_command(3'd7, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 0, 10'h155);
		send_command(KIND_CLEAR, 0, 0, 0, 0, 0, 1, 0);
		send_command(KIND_READ, 0, 0, 0, 0, 0, 0, 10'd300);
		send_command(KIND_PIXEL, 7, 7, 0, 0, 0, 0, 0);
		send_command(KIND_READ, 0, 0, 0, 0, 0, 0, 10'd7);
		send_command(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0);
		send_command(KIND_READ, 0, 0, 0, 0, 0, 0, 10'd7);

		// Random commands; the last part runs without idle gaps.
		for (int i = 0; i < 1100; i++) begin
			if (i == 950)
				quiet_tail = 1'b1;
			send_random();
		end
		in_valid <= 1'b0;

		wait_cycles = 0;
		while (board.expected_bytes.size() != 0 && wait_cycles < 200000) begin
			@(negedge clk);
			wait_cycles++;
		end
		repeat (50) @(negedge clk);

		$display("Ran %0d commands over pixel, line, circle, fill and read kinds;",
			issued);
		$display("%0d results checked against the shadow frame store.", board.checked);
		if (board.mismatches == 0 && board.expected_bytes.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
